// ===== rtl/bgcd_pkg.sv =====
`timescale 1ns / 1ps

package bgcd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRIP,
    ST_REDUCE,
    ST_FINISH
  } bgcd_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic strip;
    logic reduce;
    logic load_result;
  } bgcd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic any_zero;
    logic both_even;
    logic equal;
  } bgcd_stat_t;

endpackage

// ===== rtl/bgcd_datapath.sv =====
`timescale 1ns / 1ps

module bgcd_datapath
  import bgcd_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  bgcd_cmd_t             cmd_i,
  input  logic [DATA_WIDTH-1:0] operand_a_i,
  input  logic [DATA_WIDTH-1:0] operand_b_i,
  output bgcd_stat_t            stat_o,
  output logic [DATA_WIDTH-1:0] divisor_o
);

  localparam int KW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  logic [DATA_WIDTH-1:0] x_q, x_d;
  logic [DATA_WIDTH-1:0] y_q, y_d;
  logic [KW-1:0]         k_q, k_d;
  logic [DATA_WIDTH-1:0] result_q, result_d;

  logic                  x_gt_y;
  logic [DATA_WIDTH-1:0] big, little, diff;

  assign x_gt_y = x_q > y_q;
  assign big    = x_gt_y ? x_q : y_q;
  assign little = x_gt_y ? y_q : x_q;
  assign diff   = big - little;

  assign stat_o.any_zero  = (x_q == '0) || (y_q == '0);
  assign stat_o.both_even = !x_q[0] && !y_q[0];
  assign stat_o.equal     = x_q == y_q;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    k_d = k_q;
    if (cmd_i.load) begin
      x_d = operand_a_i;
      y_d = operand_b_i;
      k_d = '0;
    end else if (cmd_i.strip) begin
      // common factor of two
      x_d = x_q >> 1;
      y_d = y_q >> 1;
      k_d = k_q + 1'b1;
    end else if (cmd_i.reduce) begin
      if (x_q[0] && y_q[0]) begin
        // difference of two odd values is even, halve it right away
        if (x_gt_y) x_d = diff >> 1;
        else        y_d = diff >> 1;
      end else begin
        if (!x_q[0]) x_d = x_q >> 1;
        if (!y_q[0]) y_d = y_q >> 1;
      end
    end
  end

  always_comb begin
    if (stat_o.any_zero) result_d = x_q | y_q;
    else                 result_d = x_q << k_q;
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
    if (cmd_i.load_result) result_q <= result_d;
  end

  assign divisor_o = result_q;

endmodule

// ===== rtl/bgcd_ctrl.sv =====
`timescale 1ns / 1ps

module bgcd_ctrl
  import bgcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  bgcd_stat_t stat_i,
  output bgcd_cmd_t  cmd_o
);

  bgcd_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_STRIP;
      end
      ST_STRIP: begin
        if (stat_i.any_zero)        state_d = ST_FINISH;
        else if (!stat_i.both_even) state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (stat_i.equal) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_STRIP: begin
        cmd_o.strip = !stat_i.any_zero && stat_i.both_even;
      end
      ST_REDUCE: begin
        cmd_o.reduce = !stat_i.equal;
      end
      ST_FINISH: begin
        cmd_o.load_result = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.load_result)           out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |=> out_valid_q)
    else $error("result loaded but not presented");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_STRIP)
    else $error("transaction accepted without starting");

  a_reduce_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REDUCE |-> !stat_i.any_zero)
    else $error("zero operand reached the reduce loop");

  a_reduce_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REDUCE |-> !stat_i.both_even)
    else $error("common factor of two left in the reduce loop");

endmodule

// ===== rtl/binary_gcd_unit.sv =====
`timescale 1ns / 1ps
// gcd of two unsigned operands, one transaction at a time
// flow: accept, common-factor stripping at one bit per cycle, the strip/subtract loop,
//   then finish, where the result is registered once the output is free; when an operand
//   is zero, stripping goes straight to finish
// the next transaction is accepted once the unit is back in idle, also while a result
//   waits
// reset: asynchronous active low, clears the controller and the output valid

module binary_gcd_unit
  import bgcd_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] operand_a_i,
  input  logic [DATA_WIDTH-1:0] operand_b_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] divisor_o
);

  bgcd_cmd_t  cmd;
  bgcd_stat_t stat;

  bgcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bgcd_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .stat_o      (stat),
    .divisor_o   (divisor_o)
  );

endmodule
